// File: rtl/lbi_pkg.sv
// ----------------------------------------------------------------------------
// lbi_pkg
// Shared constants and types of the lane bit insertion index block.
// ----------------------------------------------------------------------------
package lbi_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned PosW    = 6;
  localparam int unsigned SrcW    = 5;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HIGH_LANE_MASK = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOW_LANE_POS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_VAR_LANE_POS   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_INDEX_BITS     = 2'd3;

  // raw configuration registers
  typedef struct packed {
    logic [DataW-1:0] high_lane_mask;
    logic [PosW-1:0]  low_lane_pos;
    logic [PosW-1:0]  var_lane_pos;
    logic [PosW-1:0]  index_bits;
  } lbi_cfg_t;

  // values derived from the configuration, kept in flops
  typedef struct packed {
    logic [DataW-1:0]           hi;        // forced-one positions
    logic [DataW-1:0]           free;      // deposit positions
    logic [DataW-1:0]           var_mask;  // variable lane bit, zero if none
    logic [DataW-1:0]           ord_mask;  // ordinal bits allowed to be set
    logic                       ok;        // index_bits covers the lanes
    logic [DataW-1:0][SrcW-1:0] src_idx;   // ordinal bit feeding each position
  } lbi_derived_t;

  localparam lbi_cfg_t CFG_RESET = '{
    high_lane_mask: '0,
    low_lane_pos:   '1,
    var_lane_pos:   '1,
    index_bits:     '0
  };

endpackage

// File: rtl/lane_bit_insertion_index.sv
// ----------------------------------------------------------------------------
// lane_bit_insertion_index
// Deposits ordinal bits around reserved address lanes (high, low, variable).
// ----------------------------------------------------------------------------
// Path: input register (ord_q), then result register (addr_q), to the first result beat.
// Throughput: 1 ordinal per cycle without a variable lane, while m_axis_tready
//   is high; with one, the single result register gives two beats, one per cycle.
// Reset: asynchronous, active low; clears the pipeline and loads the
//   register reset values (no lanes, index_bits of zero).
// ----------------------------------------------------------------------------
module lane_bit_insertion_index
  import lbi_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i,

  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DataW-1:0]   s_axis_tdata,   // [31:0] ordinal

  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DataW-1:0]   m_axis_tdata,   // [31:0] address
  output logic               m_axis_tlast
);

  localparam logic [DataW-1:0] WidthMask =
    DataW'((33'(1) << ADDR_WIDTH) - 33'(1));

  function automatic logic [DataW-1:0] lane_bit(input logic [PosW-1:0] pos);
    logic [DataW-1:0] r;
    r = '0;
    if (!pos[PosW-1] && (32'(pos) < ADDR_WIDTH)) begin
      r = DataW'(1) << pos[SrcW-1:0];
    end
    return r;
  endfunction

  function automatic lbi_derived_t derive(input lbi_cfg_t c);
    lbi_derived_t     d;
    logic [DataW-1:0] reserved;
    logic [PosW-1:0]  nres;
    logic [PosW-1:0]  ib;
    logic [PosW-1:0]  k;
    d.hi       = c.high_lane_mask & WidthMask;
    d.var_mask = lane_bit(c.var_lane_pos);
    reserved   = d.hi | lane_bit(c.low_lane_pos) | d.var_mask;
    d.free     = ~reserved & WidthMask;
    nres       = PosW'($countones(reserved));
    ib         = (32'(c.index_bits) > ADDR_WIDTH) ? PosW'(ADDR_WIDTH) : c.index_bits;
    d.ok       = (ib >= nres);
    k          = ib - nres;
    d.ord_mask = DataW'((33'(1) << k) - 33'(1));
    for (int b = 0; b < DataW; b++) begin
      d.src_idx[b] = SrcW'($countones(d.free & DataW'((33'(1) << b) - 33'(1))));
    end
    return d;
  endfunction

  // configuration, with derived values updated on the same edge
  lbi_cfg_t     cfg_q, cfg_d;
  lbi_derived_t dv_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HIGH_LANE_MASK: cfg_d.high_lane_mask = cfg_wdata_i;
        CFG_LOW_LANE_POS:   cfg_d.low_lane_pos   = cfg_wdata_i[PosW-1:0];
        CFG_VAR_LANE_POS:   cfg_d.var_lane_pos   = cfg_wdata_i[PosW-1:0];
        CFG_INDEX_BITS:     cfg_d.index_bits     = cfg_wdata_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
      dv_q  <= derive(CFG_RESET);
    end else begin
      cfg_q <= cfg_d;
      dv_q  <= derive(cfg_d);
    end
  end

  // input register
  logic             in_valid_q;
  logic [DataW-1:0] ord_q;
  logic             item_ok, out_take, out_free, load, in_go;
  logic [DataW-1:0] calc;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] addr_q, addr_d;
  logic             last_q, last_d;

  assign item_ok  = dv_q.ok && ((ord_q & ~dv_q.ord_mask) == '0);
  assign out_take = out_valid_q && m_axis_tready;
  assign out_free = !out_valid_q || (out_take && last_q);
  assign load     = in_valid_q && item_ok && out_free;
  assign in_go    = in_valid_q && (!item_ok || out_free);   // rejected beats drop
  assign s_axis_tready = !in_valid_q || in_go;

  always_comb begin
    for (int b = 0; b < DataW; b++) begin
      calc[b] = dv_q.hi[b] | (dv_q.free[b] & ord_q[dv_q.src_idx[b]]);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    addr_d      = addr_q;
    last_d      = last_q;
    if (load) begin
      out_valid_d = 1'b1;
      addr_d      = calc;
      last_d      = (dv_q.var_mask == '0);
    end else if (out_take && !last_q) begin
      addr_d = addr_q | dv_q.var_mask;     // second beat: variable lane set
      last_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b1;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ord_q <= s_axis_tdata;
    end
    addr_q <= addr_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = addr_q;
  assign m_axis_tlast  = last_q;

endmodule

// File: rtl/lbi_checker.sv
// ----------------------------------------------------------------------------
// lbi_assert
// Port-level checks of the lane bit insertion index block.
// ----------------------------------------------------------------------------
module lbi_assert
  import lbi_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [DataW-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result beat right after reset");

  // the second beat of a pair follows at once and closes the run
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("second beat of pair missing");

  // the second beat only adds the variable lane bit
  a_pair_superset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      ((m_axis_tdata & $past(m_axis_tdata)) == $past(m_axis_tdata)) &&
      ($countones(m_axis_tdata ^ $past(m_axis_tdata)) <= 1))
    else $error("second beat address not first plus one lane");

endmodule

bind lane_bit_insertion_index lbi_assert u_lbi_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: sim/lbi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbi_checker
// Watches the config port and both streams of lane_bit_insertion_index,
// predicts the deposited addresses of every accepted ordinal and compares
// each result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module lbi_checker
  import lbi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i,

  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [DataW-1:0]   s_axis_tdata,   // [31:0] ordinal

  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [DataW-1:0]   m_axis_tdata,   // [31:0] address
  input  logic               m_axis_tlast,

  output int                 fail_cnt_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [DataW-1:0] address;
    logic             last;
  } addr_beat_t;

  addr_beat_t       addr_q[$];
  addr_beat_t       exp_beat;

  // local copy of the lane registers
  logic [DataW-1:0] hi_mask;
  logic [PosW-1:0]  low_pos;
  logic [PosW-1:0]  var_pos;
  logic [PosW-1:0]  idx_bits;

  // a set sign bit means the lane is absent
  function automatic logic [DataW-1:0] lane_onehot(input logic [PosW-1:0] pos);
    lane_onehot = '0;
    if (!pos[PosW-1]) lane_onehot[pos[PosW-2:0]] = 1'b1;
  endfunction

  task automatic predict_addresses(input logic [DataW-1:0] ord);
    logic [DataW-1:0] var_bit;
    logic [DataW-1:0] reserved;
    logic [DataW-1:0] addr;
    int unsigned      nres;
    int unsigned      span;
    int unsigned      src;
    addr_beat_t       nb;
    var_bit  = lane_onehot(var_pos);
    reserved = hi_mask | lane_onehot(low_pos) | var_bit;
    nres     = $countones(reserved);
    span     = (idx_bits > DataW) ? DataW : idx_bits;
    if (span < nres) return;
    span = span - nres;
    if ((64'(ord) >> span) != 64'd0) return;
    addr = hi_mask;
    src  = 0;
    for (int b = 0; b < DataW; b++) begin
      if (!reserved[b]) begin
        addr[b] = ord[src];
        src++;
      end
    end
    nb.address = addr;
    nb.last    = (var_bit == '0);
    addr_q = {addr_q, nb};
    if (var_bit != '0) begin
      nb.address = addr | var_bit;
      nb.last    = 1'b1;
      addr_q = {addr_q, nb};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_mask    = CFG_RESET.high_lane_mask;
      low_pos    = CFG_RESET.low_lane_pos;
      var_pos    = CFG_RESET.var_lane_pos;
      idx_bits   = CFG_RESET.index_bits;
      addr_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (addr_q.size() == 0) begin
          $display("%0t: unexpected result beat: address %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          fail_cnt_o++;
        end else begin
          exp_beat = addr_q.pop_front();
          if (m_axis_tdata !== exp_beat.address) begin
            $display("%0t: address mismatch: expected %h, actual %h",
                     $time, exp_beat.address, m_axis_tdata);
            fail_cnt_o++;
          end
          if (m_axis_tlast !== exp_beat.last) begin
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, exp_beat.last, m_axis_tlast);
            fail_cnt_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HIGH_LANE_MASK: hi_mask  = cfg_wdata_i;
          CFG_LOW_LANE_POS:   low_pos  = cfg_wdata_i[PosW-1:0];
          CFG_VAR_LANE_POS:   var_pos  = cfg_wdata_i[PosW-1:0];
          CFG_INDEX_BITS:     idx_bits = cfg_wdata_i[PosW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_addresses(s_axis_tdata);
      pending_o = addr_q.size();
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ordinals through lane_bit_insertion_index under a series of lane
// settings (directed corner cases, then random), with random stalls on
// both streams; lbi_checker predicts and checks every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import lbi_pkg::*;

  localparam logic [PosW-1:0] LANE_NONE  = '1;
  localparam int              RAND_ITEMS = 1200;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = CFG_HIGH_LANE_MASK;
  logic [DataW-1:0]   cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [DataW-1:0]   s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [DataW-1:0]   m_axis_tdata;
  logic               m_axis_tlast;

  int                 fail_cnt;
  int                 pending;
  bit                 no_idle = 1'b0;
  int                 span;   // ordinal bits accepted under current lanes; <0: none

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  lane_bit_insertion_index #(.ADDR_WIDTH(32)) uut (.*);

  lbi_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 21);
  end

  task automatic send_ordinal(input logic [DataW-1:0] ord);
    if (!no_idle && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 21);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ord;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold the sender until every predicted beat has come out
  task automatic wait_results(input bit settle);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    // rejected ordinals may still be in flight
    if (settle) repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_lanes(input logic [DataW-1:0] mask, input logic [PosW-1:0] low,
                           input logic [PosW-1:0] vpos, input logic [PosW-1:0] ib);
    logic [DataW-1:0] res;
    wait_results(1'b1);
    // upper bits of the narrow registers are junk and must be ignored
    write_reg(CFG_HIGH_LANE_MASK, mask);
    write_reg(CFG_LOW_LANE_POS,   {26'($urandom), low});
    write_reg(CFG_VAR_LANE_POS,   {26'($urandom), vpos});
    write_reg(CFG_INDEX_BITS,     {26'($urandom), ib});
    cfg_we_i <= 1'b0;
    res = mask;
    if (!low[PosW-1])  res[low[PosW-2:0]]  = 1'b1;
    if (!vpos[PosW-1]) res[vpos[PosW-2:0]] = 1'b1;
    span = ((ib > DataW) ? DataW : int'(ib)) - $countones(res);
  endtask

  function automatic logic [DataW-1:0] pick_ordinal();
    logic [DataW-1:0] fit;
    int               r;
    r = $urandom_range(99);
    if (span < 0) return $urandom;
    fit = (span >= DataW) ? '1 : DataW'((64'd1 << span) - 64'd1);
    if (r < 80) return $urandom & fit;
    if (r < 88) return fit;
    if (r < 94 && span < DataW) return DataW'(64'd1 << span);
    return $urandom;
  endfunction

  task automatic random_lanes();
    logic [DataW-1:0] mask;
    logic [PosW-1:0]  low;
    logic [PosW-1:0]  vpos;
    logic [PosW-1:0]  ib;
    logic [DataW-1:0] res;
    int               r;
    int               nres;
    r = $urandom_range(99);
    if (r < 35)      mask = '0;
    else if (r < 70) mask = $urandom & $urandom & $urandom;
    else if (r < 85) mask = $urandom & $urandom;
    else if (r < 95) mask = $urandom;
    else             mask = '1;
    low  = ($urandom_range(99) < 30) ? PosW'($urandom_range(32, 63)) : PosW'($urandom_range(0, 31));
    vpos = ($urandom_range(99) < 35) ? PosW'($urandom_range(32, 63)) : PosW'($urandom_range(0, 31));
    res = mask;
    if (!low[PosW-1])  res[low[PosW-2:0]]  = 1'b1;
    if (!vpos[PosW-1]) res[vpos[PosW-2:0]] = 1'b1;
    nres = $countones(res);
    r = $urandom_range(99);
    if (r < 85)      ib = PosW'(nres + $urandom_range(0, DataW - nres));
    else if (r < 90) ib = PosW'($urandom_range(33, 63));
    else             ib = PosW'($urandom_range(0, 63));
    set_lanes(mask, low, vpos, ib);
  endtask

  initial begin
    int sent;
    int phase;
    int n;
    int pause_at;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset lanes: nothing reserved, index_bits of zero, only ordinal zero fits
    span = 0;
    send_ordinal(32'h0000_0000);
    send_ordinal(32'h0000_0001);
    // plain pass-through
    set_lanes(32'h0000_0000, LANE_NONE, LANE_NONE, 6'd32);
    send_ordinal(32'hFFFF_FFFF);
    send_ordinal(32'hA5A5_A5A5);
    send_ordinal(32'h5A5A_5A5A);
    // every position a high lane, low and variable lanes overlap it
    set_lanes(32'hFFFF_FFFF, 6'd31, 6'd5, 6'd32);
    send_ordinal(32'h0000_0000);
    send_ordinal(32'h0000_0001);
    // lanes at both ends, oversized index_bits
    set_lanes(32'h0000_F000, 6'd0, 6'd31, 6'd63);
    send_ordinal(32'h03FF_FFFF);
    send_ordinal(32'h0000_0000);
    send_ordinal(32'h0400_0000);
    send_ordinal(32'h0123_4567);
    // low and variable lane on the same bit
    set_lanes(32'h8000_0001, 6'd7, 6'd7, 6'd20);
    send_ordinal(32'h0001_FFFF);
    send_ordinal(32'h0002_0000);
    send_ordinal(32'h0000_ABCD);
    // negative positions other than all ones
    set_lanes(32'h0000_0000, 6'b100000, 6'b101111, 6'd12);
    send_ordinal(32'h0000_0FFF);
    send_ordinal(32'h0000_1000);
    send_ordinal(32'h0000_0800);
    // index_bits below the lane count
    set_lanes(32'h0000_00FF, LANE_NONE, 6'd3, 6'd4);
    send_ordinal(32'h0000_0000);
    send_ordinal(32'h0000_0005);
    // exactly as many index bits as lanes
    set_lanes(32'h0000_0000, 6'd31, 6'd0, 6'd2);
    send_ordinal(32'h0000_0000);
    send_ordinal(32'h0000_0001);

    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      random_lanes();
      no_idle  = (phase == 3);
      n        = $urandom_range(30, 100);
      pause_at = (phase == 1 || $urandom_range(7) == 0) ? $urandom_range(1, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
        if (i == pause_at) wait_results(1'b0);
        send_ordinal(pick_ordinal());
      end
      sent += n;
      phase++;
    end
    no_idle = 1'b0;

    wait_results(1'b1);
    repeat (6) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
